[design/rbt_pkg.sv]
package rbt_pkg;

  localparam int unsigned DelayW = 31;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 3;

  localparam logic [DelayW-1:0] DelayMax = {DelayW{1'b1}};
  localparam logic [TimeW-1:0]  TimeMax  = {TimeW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Input kinds
  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  // Register indexes on the configuration port
  typedef enum logic [IdxW-1:0] {
    CFG_FIRST_DELAY     = 3'd0,
    CFG_MAX_DELAY       = 3'd1,
    CFG_DELAY_INCREMENT = 3'd2,
    CFG_DOUBLING_MODE   = 3'd3,
    CFG_RETRY_LIMIT     = 3'd4,
    CFG_OVERALL_TIMEOUT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DelayW-1:0] first_delay;
    logic [CfgW-1:0]   max_delay;        // signed, negative = no clamp
    logic [DelayW-1:0] delay_increment;
    logic              doubling_mode;
    logic [CfgW-1:0]   retry_limit;      // signed, negative = unlimited
    logic [CfgW-1:0]   overall_timeout;  // signed, negative = none
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] retry_count;
    logic [DelayW-1:0] current_delay;
    logic [TimeW-1:0]  deadline_ms;
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              give_up;
    logic [DelayW-1:0] delay_ms;
  } result_t;

endpackage

[design/rbt_step.sv]
module rbt_step
  import rbt_pkg::*;
(
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic             opcode_i,
  input  logic [TimeW-1:0] now_ms_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [CountW-1:0] cnt_inc;
  logic              limit_hit;
  logic              first_retry;
  logic              second_retry;
  logic [TimeW:0]    dl_sum;
  logic [TimeW-1:0]  dl_new;
  logic [DelayW:0]   add_sum;
  logic [DelayW-1:0] add_b;
  logic [DelayW-1:0] delay_step;
  logic              past_deadline;
  logic [DelayW-1:0] delay_clamp;
  logic [TimeW:0]    end_time;
  logic [TimeW-1:0]  time_left;
  logic [DelayW-1:0] delay_final;

  // Saturating retry count and limit check
  assign cnt_inc   = (state_i.retry_count == CountMax) ? state_i.retry_count
                                                       : state_i.retry_count + 1'b1;
  assign limit_hit = !cfg_i.retry_limit[CfgW-1] &&
                     (cnt_inc > {1'b0, cfg_i.retry_limit[CfgW-2:0]});

  assign first_retry  = (cnt_inc == CountW'(1));
  assign second_retry = (cnt_inc == CountW'(2));

  // Deadline armed on the first retry, saturating at the top of the time range
  assign dl_sum = {1'b0, now_ms_i} + (TimeW+1)'(cfg_i.overall_timeout[CfgW-2:0]);
  always_comb begin
    dl_new = state_i.deadline_ms;
    if (first_retry && !cfg_i.overall_timeout[CfgW-1]) begin
      dl_new = dl_sum[TimeW] ? TimeMax : dl_sum[TimeW-1:0];
    end
  end

  // Delay growth: linear step, or doubling from the third retry on
  assign add_b   = (!second_retry && cfg_i.doubling_mode) ? state_i.current_delay
                                                          : cfg_i.delay_increment;
  assign add_sum = {1'b0, state_i.current_delay} + {1'b0, add_b};
  assign delay_step = first_retry  ? cfg_i.first_delay :
                      add_sum[DelayW] ? DelayMax : add_sum[DelayW-1:0];

  assign past_deadline = (dl_new != '0) && (now_ms_i >= dl_new);

  // Clamp to max delay, then to the time left before the deadline
  always_comb begin
    delay_clamp = delay_step;
    if (!cfg_i.max_delay[CfgW-1] && (delay_step > cfg_i.max_delay[CfgW-2:0])) begin
      delay_clamp = cfg_i.max_delay[CfgW-2:0];
    end
  end

  assign end_time  = {1'b0, now_ms_i} + (TimeW+1)'(delay_clamp);
  assign time_left = dl_new - now_ms_i;

  always_comb begin
    delay_final = delay_clamp;
    if ((dl_new != '0) && (end_time > {1'b0, dl_new})) begin
      delay_final = time_left[DelayW-1:0];
    end
  end

  // Next state and result
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (op_e'(opcode_i))
      OP_RESTART: begin
        state_o = '0;
      end
      OP_REQUEST: begin
        result_o.valid      = 1'b1;
        state_o.retry_count = cnt_inc;
        if (limit_hit) begin
          result_o.give_up = 1'b1;
        end else if (past_deadline) begin
          state_o.current_delay = delay_step;
          state_o.deadline_ms   = dl_new;
          result_o.give_up      = 1'b1;
        end else begin
          state_o.current_delay = delay_final;
          state_o.deadline_ms   = dl_new;
          result_o.delay_ms     = delay_final;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

[design/reconnect_backoff_timer_core.sv]
// Reconnect backoff timer core.
// Path: an accepted request is loaded into the input register, and its result
// into the result register once the result slot is free or being read out; a
// restart gives no result.
// Throughput: one item per cycle while the result stream is not stalled.
// Reset: rst_ni low clears both registers' valid flags, the retry state and
// the configuration to its defaults (no clamp, no limit, no timeout).
module reconnect_backoff_timer_core
  import rbt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Input stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [47:0]     s_axis_tdata,   // [47:0] now_ms
  input  logic            s_axis_tuser,   // [0] opcode
  // Result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // [30:0] delay_ms, [31] zero
  output logic            m_axis_tuser,   // [0] give_up
  // Configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  cfg_t              cfg_q, cfg_d;
  state_t            state_q, state_d;
  logic              in_valid_q;
  logic              in_op_q;
  logic [TimeW-1:0]  in_now_q;
  logic              out_valid_q;
  logic              out_give_up_q;
  logic [DelayW-1:0] out_delay_q;
  result_t           step_res;
  logic              advance;

  // Configuration register writes; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_DELAY:     cfg_d.first_delay     = cfg_data_i[DelayW-1:0];
        CFG_MAX_DELAY:       cfg_d.max_delay       = cfg_data_i;
        CFG_DELAY_INCREMENT: cfg_d.delay_increment = cfg_data_i[DelayW-1:0];
        CFG_DOUBLING_MODE:   cfg_d.doubling_mode   = cfg_data_i[0];
        CFG_RETRY_LIMIT:     cfg_d.retry_limit     = cfg_data_i;
        CFG_OVERALL_TIMEOUT: cfg_d.overall_timeout = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_delay     <= '0;
      cfg_q.max_delay       <= '1;
      cfg_q.delay_increment <= '0;
      cfg_q.doubling_mode   <= 1'b0;
      cfg_q.retry_limit     <= '1;
      cfg_q.overall_timeout <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Item moves on when it is a restart or the result slot is free or being read out
  assign advance = in_valid_q &&
                   ((op_e'(in_op_q) == OP_RESTART) || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  rbt_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .opcode_i (in_op_q),
    .now_ms_i (in_now_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= s_axis_tuser;
      in_now_q <= s_axis_tdata[TimeW-1:0];
    end
  end

  // Retry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.valid) begin
      out_give_up_q <= step_res.give_up;
      out_delay_q   <= step_res.delay_ms;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_delay_q};
  assign m_axis_tuser  = out_give_up_q;

endmodule

[design/rbt_checker.sv]
module rbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Giving up always carries a zero delay
  a_give_up_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("give_up with nonzero delay");

  // Delay never exceeds 31 bits
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("delay out of range");

  // With the result slot empty the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

endmodule

bind reconnect_backoff_timer_core rbt_checker u_rbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[bench/tb_reconnect_backoff_timer_core.sv]
`timescale 1ns / 1ps

module tb_reconnect_backoff_timer_core;
  import rbt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;
  localparam int SettleCyc  = 4;

  // Spare register indexes, writes there must have no effect
  localparam logic [IdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IdxW-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_PATTERN
  } rdy_mode_e;

  typedef struct {
    op_e              op;
    logic [TimeW-1:0] now;
  } attempt_t;

  typedef struct {
    logic              give_up;
    logic [DelayW-1:0] delay_ms;
  } verdict_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [47:0]     s_axis_tdata = '0;    // [47:0] now_ms
  logic            s_axis_tuser = 1'b0;  // [0] opcode
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;         // [30:0] delay_ms, [31] zero
  logic            m_axis_tuser;         // [0] give_up
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [IdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  reconnect_backoff_timer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block's registers and retry state
  cfg_t     regs = '{first_delay: '0, max_delay: '1, delay_increment: '0,
                     doubling_mode: 1'b0, retry_limit: '1, overall_timeout: '1};
  state_t   seq  = '0;
  attempt_t pending_q[$];
  verdict_t verdict_q[$];
  int       mismatches = 0;

  // Next retry delay for one accepted request; restarts clear the sequence
  function automatic void predict_backoff(input attempt_t a);
    logic [TimeW:0]  t_sum;
    logic [DelayW:0] d_sum;
    logic            quit;
    verdict_t        v;
    if (a.op == OP_RESTART) begin
      seq = '0;
      return;
    end
    if (seq.retry_count != CountMax) seq.retry_count = seq.retry_count + 1'b1;
    quit = !regs.retry_limit[CfgW-1] && (seq.retry_count > regs.retry_limit);
    if (!quit) begin
      if (seq.retry_count == 1) begin
        if (!regs.overall_timeout[CfgW-1]) begin
          t_sum = {1'b0, a.now} + regs.overall_timeout;
          seq.deadline_ms = t_sum[TimeW] ? TimeMax : t_sum[TimeW-1:0];
        end
        seq.current_delay = regs.first_delay;
      end else begin
        d_sum = {1'b0, seq.current_delay} +
                ((seq.retry_count == 2 || !regs.doubling_mode) ?
                 regs.delay_increment : seq.current_delay);
        seq.current_delay = d_sum[DelayW] ? DelayMax : d_sum[DelayW-1:0];
      end
      if (seq.deadline_ms != '0 && a.now >= seq.deadline_ms) begin
        quit = 1'b1;
      end else begin
        if (!regs.max_delay[CfgW-1] && {1'b0, seq.current_delay} > regs.max_delay)
          seq.current_delay = regs.max_delay[DelayW-1:0];
        // clamp to the time left before the deadline
        if (seq.deadline_ms != '0 &&
            ({1'b0, a.now} + seq.current_delay) > {1'b0, seq.deadline_ms}) begin
          t_sum = {1'b0, seq.deadline_ms} - {1'b0, a.now};
          seq.current_delay = t_sum[DelayW-1:0];
        end
      end
    end
    v.give_up  = quit;
    v.delay_ms = quit ? '0 : seq.current_delay;
    verdict_q.push_back(v);
  endfunction

  // Input driver: bursts of requests with random gaps in between
  attempt_t cur;
  bit       offer = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (offer && s_axis_tready) begin
        predict_backoff(cur);
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur   = pending_q.pop_front();
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata  <= cur.now;
      s_axis_tuser  <= cur.op;
    end
  end

  // Result side back-pressure, plus one long hold-off on demand
  bit        hold_go = 1'b0;
  int        hold_cnt = 0;
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  int        mode_left = 0;
  logic [7:0] rdy_pat = 8'hff;
  logic      rdy;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = LongHold;
        rdy      = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode  = rdy_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          rdy_pat   = $urandom;
        end
        mode_left--;
        case (rdy_mode)
          RDY_ALWAYS: rdy = 1'b1;
          RDY_COIN:   rdy = $urandom_range(0, 1);
          RDY_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
          default: begin
            rdy_pat = {rdy_pat[6:0], rdy_pat[7]};
            rdy     = rdy_pat[0];
          end
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Result checker
  verdict_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: give_up %0b delay_ms %0d", m_axis_tuser,
                   m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tuser !== want.give_up || m_axis_tdata !== {1'b0, want.delay_ms}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: give_up exp %0b got %0b, delay_ms exp %0d got %0d (tdata %h)",
                     want.give_up, m_axis_tuser, want.delay_ms, m_axis_tdata[30:0],
                     m_axis_tdata);
        end
      end
    end
  end

  // Watchdog
  int cycle_cnt = 0;

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL reconnect_backoff_timer_core");
    $finish;
  end

  task automatic push_item(input op_e op, input logic [TimeW-1:0] now);
    attempt_t a;
    a.op  = op;
    a.now = now;
    pending_q.push_back(a);
  endtask

  // One register write request; valid stays high across back-to-back writes
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FIRST_DELAY:     regs.first_delay     = data[DelayW-1:0];
      CFG_MAX_DELAY:       regs.max_delay       = data;
      CFG_DELAY_INCREMENT: regs.delay_increment = data[DelayW-1:0];
      CFG_DOUBLING_MODE:   regs.doubling_mode   = data[0];
      CFG_RETRY_LIMIT:     regs.retry_limit     = data;
      CFG_OVERALL_TIMEOUT: regs.overall_timeout = data;
      default: ;
    endcase
  endtask

  // Write all six registers; unused upper bits and a spare index get noise
  task automatic program_regs(input cfg_t c);
    write_reg(CFG_FIRST_DELAY, {1'($urandom_range(0, 1)), c.first_delay});
    write_reg(CFG_MAX_DELAY, c.max_delay);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    write_reg(CFG_DELAY_INCREMENT, {1'($urandom_range(0, 1)), c.delay_increment});
    write_reg(CFG_DOUBLING_MODE, {31'($urandom), c.doubling_mode});
    write_reg(CFG_RETRY_LIMIT, c.retry_limit);
    write_reg(CFG_OVERALL_TIMEOUT, c.overall_timeout);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every queued item went in and every result came out
  task automatic wait_idle();
    while (pending_q.size() != 0 || offer || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic cfg_t pick_regs();
    cfg_t c;
    case ($urandom_range(0, 3))
      0: c.first_delay = '0;
      1: c.first_delay = $urandom_range(1, 300);
      2: c.first_delay = DelayMax;
      default: c.first_delay = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: c.max_delay = '1;
      1: c.max_delay = '0;
      2: c.max_delay = $urandom_range(1, 2000);
      3: c.max_delay = 32'h7fff_ffff;
      default: c.max_delay = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: c.delay_increment = '0;
      1: c.delay_increment = $urandom_range(1, 300);
      2: c.delay_increment = DelayMax;
      default: c.delay_increment = $urandom;
    endcase
    c.doubling_mode = $urandom_range(0, 1);
    case ($urandom_range(0, 4))
      0: c.retry_limit = '1;
      1: c.retry_limit = 32'h8000_0000 | $urandom;
      2: c.retry_limit = '0;
      3: c.retry_limit = $urandom_range(1, 12);
      default: c.retry_limit = 32'h7fff_ffff;
    endcase
    case ($urandom_range(0, 5))
      0: c.overall_timeout = '1;
      1: c.overall_timeout = '0;
      2: c.overall_timeout = $urandom_range(1, 3000);
      3: c.overall_timeout = 32'h7fff_ffff;
      4: c.overall_timeout = $urandom;
      default: c.overall_timeout = $urandom_range(0, 300);
    endcase
    return c;
  endfunction

  function automatic logic [TimeW-1:0] pick_base();
    logic [TimeW-1:0] t;
    case ($urandom_range(0, 3))
      0: t = $urandom_range(0, 100);
      1: t = {$urandom, $urandom};
      2: t = TimeMax - $urandom_range(0, 5000);
      default: t = $urandom_range(0, 100000);
    endcase
    return t;
  endfunction

  // Mostly restart-then-retries sequences with rising time, some noise
  task automatic queue_random(input int n);
    int               left;
    int               run;
    logic [TimeW-1:0] t;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(op_e'($urandom_range(0, 1)), {$urandom, $urandom});
        left--;
      end else begin
        // an occasional sequence carries on without its restart
        if ($urandom_range(0, 7) != 0) begin
          push_item(OP_RESTART, {$urandom, $urandom});
          left--;
        end
        t   = pick_base();
        run = $urandom_range(1, 12);
        repeat (run) begin
          push_item(OP_REQUEST, t);
          t += ($urandom_range(0, 5) == 0) ? TimeW'($urandom) : $urandom_range(0, 500);
          left--;
        end
      end
    end
  endtask

  initial begin
    cfg_t c;
    int   p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Doubling up to the clamp, retry limit, deadline clamp and deadline give-up
    c = '{first_delay: 100, max_delay: 1000, delay_increment: 50, doubling_mode: 1'b1,
          retry_limit: 5, overall_timeout: 2000};
    program_regs(c);
    push_item(OP_RESTART, '0);
    push_item(OP_REQUEST, 0);
    push_item(OP_REQUEST, 10);
    push_item(OP_REQUEST, 20);
    push_item(OP_REQUEST, 30);
    push_item(OP_REQUEST, 40);
    push_item(OP_REQUEST, 50);
    push_item(OP_RESTART, TimeMax);
    push_item(OP_REQUEST, 1990);
    push_item(OP_REQUEST, 3900);
    push_item(OP_REQUEST, 3990);
    push_item(OP_RESTART, '0);
    // deadline sum saturates, then time runs backwards
    push_item(OP_REQUEST, TimeMax);
    push_item(OP_REQUEST, 5);
    wait_idle();

    // Zero timeout at time zero means no deadline; delay sums saturate
    c = '{first_delay: DelayMax, max_delay: 32'hffff_ffff, delay_increment: 1,
          doubling_mode: 1'b0, retry_limit: 32'hffff_ffff, overall_timeout: 0};
    program_regs(c);
    push_item(OP_RESTART, '0);
    push_item(OP_REQUEST, 0);
    push_item(OP_REQUEST, 1);
    push_item(OP_REQUEST, 2);
    wait_idle();

    // Zero clamp, then the retry limit of one is passed
    c = '{first_delay: 0, max_delay: 0, delay_increment: DelayMax, doubling_mode: 1'b1,
          retry_limit: 1, overall_timeout: 32'h7fff_ffff};
    program_regs(c);
    push_item(OP_RESTART, '0);
    push_item(OP_REQUEST, 9);
    push_item(OP_REQUEST, 10);
    wait_idle();

    // Random phases, first one back at the reset settings
    for (p = 0; p < 16; p++) begin
      if (p == 0)
        c = '{first_delay: '0, max_delay: '1, delay_increment: '0, doubling_mode: 1'b0,
              retry_limit: '1, overall_timeout: '1};
      else
        c = pick_regs();
      program_regs(c);
      queue_random(100);
      if (p == 3) hold_go = 1'b1;
      wait_idle();
    end

    if (mismatches == 0)
      $display("PASS reconnect_backoff_timer_core");
    else
      $display("FAIL reconnect_backoff_timer_core");
    $finish;
  end

endmodule
